// ----- design/g2g_pkg.sv -----
// ----------------------------------------------------------------------------
// g2g_pkg
// shared constants, types and the arctangent table of the go-to-goal block
// ----------------------------------------------------------------------------
package g2g_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRAC_BITS         = 12;
    localparam int GUARD_BITS        = 8;
    localparam int ANG_SHIFT         = 39 - FRAC_BITS;
    localparam int TABLE_LEN         = 24;

    localparam int POS_W  = 20;
    localparam int DIFF_W = 21;
    localparam int ANG_W  = 16;
    localparam int SPD_W  = 19;
    localparam int GAIN_W = 12;
    localparam int CV_W   = 32;
    localparam int DIST_W = 22;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;

    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
    localparam logic [17:0] PI_Q16       = 18'd205887;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_DISTANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_GAIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINEAR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGULAR   = 3'd6;

    localparam logic signed [POS_W-1:0] RST_TARGET_X      = 20'sd45056;
    localparam logic signed [POS_W-1:0] RST_TARGET_Y      = 20'sd45056;
    localparam logic [SPD_W-1:0]        RST_STOP_DISTANCE = 19'd410;
    localparam logic [GAIN_W-1:0]       RST_LINEAR_GAIN   = 12'd384;
    localparam logic [GAIN_W-1:0]       RST_ANGULAR_GAIN  = 12'd1536;
    localparam logic [SPD_W-1:0]        RST_MAX_LINEAR    = 19'd12288;
    localparam logic [SPD_W-1:0]        RST_MAX_ANGULAR   = 19'd16384;

    localparam logic [CV_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic signed [ANG_W-1:0] hd;
        logic                    zero;
    } t_side;

endpackage

// ----- design/g2g_cordic.sv -----
// ----------------------------------------------------------------------------
// g2g_cordic
// unrolled cordic vectoring pipeline, one micro-rotation per register stage
// ----------------------------------------------------------------------------
module g2g_cordic #(
    parameter int CORDIC_STAGES = g2g_pkg::CORDIC_STAGES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic signed [g2g_pkg::CV_W-1:0]  i_x,
    input  logic signed [g2g_pkg::CV_W-1:0]  i_y,
    input  logic        [g2g_pkg::CV_W-1:0]  i_z,
    input  g2g_pkg::t_side                   i_side,
    output logic                             o_valid,
    output logic signed [g2g_pkg::CV_W-1:0]  o_x,
    output logic        [g2g_pkg::CV_W-1:0]  o_z,
    output g2g_pkg::t_side                   o_side
);
    import g2g_pkg::*;

    logic signed [CV_W-1:0] w_x [CORDIC_STAGES+1];
    logic signed [CV_W-1:0] w_y [CORDIC_STAGES+1];
    logic        [CV_W-1:0] w_z [CORDIC_STAGES+1];
    t_side                  w_s [CORDIC_STAGES+1];
    logic                   w_v [CORDIC_STAGES+1];

    assign w_x[0] = i_x;
    assign w_y[0] = i_y;
    assign w_z[0] = i_z;
    assign w_s[0] = i_side;
    assign w_v[0] = i_valid;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic signed [CV_W-1:0] r_x, r_y, n_x, n_y;
        logic        [CV_W-1:0] r_z, n_z;
        t_side                  r_s;
        logic                   r_v;

        always_comb begin
            if (!w_y[i][CV_W-1]) begin
                n_x = w_x[i] + (w_y[i] >>> i);
                n_y = w_y[i] - (w_x[i] >>> i);
                n_z = w_z[i] + ATAN_TABLE[i];
            end else begin
                n_x = w_x[i] - (w_y[i] >>> i);
                n_y = w_y[i] + (w_x[i] >>> i);
                n_z = w_z[i] - ATAN_TABLE[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_s <= w_s[i];
            end
        end

        assign w_x[i+1] = r_x;
        assign w_y[i+1] = r_y;
        assign w_z[i+1] = r_z;
        assign w_s[i+1] = r_s;
        assign w_v[i+1] = r_v;
    end

    assign o_valid = w_v[CORDIC_STAGES];
    assign o_x     = w_x[CORDIC_STAGES];
    assign o_z     = w_z[CORDIC_STAGES];
    assign o_side  = w_s[CORDIC_STAGES];

endmodule

// ----- design/go_to_goal_p_controller_top.sv -----
// ----------------------------------------------------------------------------
// go_to_goal_p_controller_top
// pipeline: stage a, stage b, the cordic stages, stages 1 to 3 and the output register
// throughput: one pose per cycle while the skid register is empty, set by the unrolled cordic pipeline
// an output skid register keeps the pipeline moving while one result waits; once it is full the pipeline stalls
// reset: synchronous, clears valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module go_to_goal_p_controller_top #(
    parameter int CORDIC_STAGES = g2g_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic        [g2g_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [g2g_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [g2g_pkg::POS_W-1:0]     i_pose_x,
    input  logic signed [g2g_pkg::POS_W-1:0]     i_pose_y,
    input  logic signed [g2g_pkg::ANG_W-1:0]     i_pose_heading,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic        [g2g_pkg::SPD_W-1:0]     o_linear_speed,
    output logic signed [g2g_pkg::POS_W-1:0]     o_angular_speed,
    output logic                                 o_goal_reached
);
    import g2g_pkg::*;

    // configuration registers
    logic signed [POS_W-1:0]  r_target_x, r_target_y;
    logic        [SPD_W-1:0]  r_stop_distance, r_max_linear, r_max_angular;
    logic        [GAIN_W-1:0] r_linear_gain, r_angular_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x      <= RST_TARGET_X;
            r_target_y      <= RST_TARGET_Y;
            r_stop_distance <= RST_STOP_DISTANCE;
            r_linear_gain   <= RST_LINEAR_GAIN;
            r_angular_gain  <= RST_ANGULAR_GAIN;
            r_max_linear    <= RST_MAX_LINEAR;
            r_max_angular   <= RST_MAX_ANGULAR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TARGET_X:      r_target_x      <= i_cfg_data;
                CFG_TARGET_Y:      r_target_y      <= i_cfg_data;
                CFG_STOP_DISTANCE: r_stop_distance <= i_cfg_data[SPD_W-1:0];
                CFG_LINEAR_GAIN:   r_linear_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_ANGULAR_GAIN:  r_angular_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_MAX_LINEAR:    r_max_linear    <= i_cfg_data[SPD_W-1:0];
                CFG_MAX_ANGULAR:   r_max_angular   <= i_cfg_data[SPD_W-1:0];
                default: ;
            endcase
        end
    end

    logic r_sv;
    logic w_en;
    assign w_en       = !r_sv;
    assign o_in_ready = w_en;

    // stage a: difference vector
    logic                     r_va;
    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic signed [ANG_W-1:0]  r_hd_a;

    // stage b: pre-rotation into the right half plane
    logic                   r_vb;
    logic signed [CV_W-1:0] r_bx, r_by;
    logic        [CV_W-1:0] r_bz;
    t_side                  r_bs;
    logic signed [CV_W-1:0] n_bx, n_by;
    logic        [CV_W-1:0] n_bz;

    always_comb begin
        n_bx = {{(CV_W-DIFF_W-GUARD_BITS){r_dx[DIFF_W-1]}}, r_dx, {GUARD_BITS{1'b0}}};
        n_by = {{(CV_W-DIFF_W-GUARD_BITS){r_dy[DIFF_W-1]}}, r_dy, {GUARD_BITS{1'b0}}};
        n_bz = '0;
        if (r_dx[DIFF_W-1]) begin
            n_bx = -n_bx;
            n_by = -n_by;
            n_bz = {1'b1, {(CV_W-1){1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (w_en) begin
            r_va <= i_in_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx      <= DIFF_W'(r_target_x) - DIFF_W'(i_pose_x);
            r_dy      <= DIFF_W'(r_target_y) - DIFF_W'(i_pose_y);
            r_hd_a    <= i_pose_heading;
            r_bx      <= n_bx;
            r_by      <= n_by;
            r_bz      <= n_bz;
            r_bs.hd   <= r_hd_a;
            r_bs.zero <= (r_dx == '0) && (r_dy == '0);
        end
    end

    logic                   w_cv;
    logic signed [CV_W-1:0] w_cx;
    logic        [CV_W-1:0] w_cz;
    t_side                  w_cs;

    g2g_cordic #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_vb),
        .i_x     (r_bx),
        .i_y     (r_by),
        .i_z     (r_bz),
        .i_side  (r_bs),
        .o_valid (w_cv),
        .o_x     (w_cx),
        .o_z     (w_cz),
        .o_side  (w_cs)
    );

    // stage 1: gain correction product, heading error
    logic                    r_v1;
    logic [47:0]             r_dprod;
    logic signed [ANG_W-1:0] r_err;
    logic [CV_W-1:0]         w_zr;
    logic [ANG_W-1:0]        w_bearing;

    assign w_zr      = w_cz + 32'h0000_8000;
    assign w_bearing = w_cs.zero ? '0 : w_zr[CV_W-1:CV_W-ANG_W];

    // stage 2: distance, reached flag, error times gain
    logic                    r_v2;
    logic [DIST_W-1:0]       r_dist;
    logic                    r_reached2;
    logic signed [28:0]      r_eg;
    logic [47:0]             w_dsum;

    assign w_dsum = r_dprod + 48'h80_0000;

    // stage 3: speed products
    logic                    r_v3;
    logic                    r_reached3;
    logic [33:0]             r_lprod;
    logic signed [47:0]      r_aprod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= w_cv;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dprod    <= 48'(unsigned'(w_cx)) * 48'(INV_GAIN_Q16);
            r_err      <= signed'(w_bearing - w_cs.hd);
            r_dist     <= w_dsum[DIST_W+23:24];
            r_reached2 <= {1'b0, w_dsum[DIST_W+23:24]} < (DIST_W+1)'(r_stop_distance);
            r_eg       <= 29'(r_err) * signed'({17'd0, r_angular_gain});
            r_reached3 <= r_reached2;
            r_lprod    <= 34'(r_dist) * 34'(r_linear_gain);
            r_aprod    <= 48'(r_eg) * signed'({30'd0, PI_Q16});
        end
    end

    // output stage: rounding and clamps
    logic [33:0]             w_lsum;
    logic [25:0]             w_lin_raw;
    logic [SPD_W-1:0]        w_lin;
    logic signed [47:0]      w_asum, w_ash, w_amax;
    logic signed [POS_W-1:0] w_ang;

    always_comb begin
        w_lsum    = r_lprod + 34'd128;
        w_lin_raw = w_lsum[33:8];
        w_lin     = (w_lin_raw > 26'(r_max_linear)) ? r_max_linear : w_lin_raw[SPD_W-1:0];
        w_asum    = r_aprod + (48'sd1 <<< (ANG_SHIFT - 1));
        w_ash     = w_asum >>> ANG_SHIFT;
        w_amax    = signed'(48'(r_max_angular));
        if (w_ash > w_amax) begin
            w_ang = POS_W'(w_amax);
        end else if (w_ash < -w_amax) begin
            w_ang = POS_W'(-w_amax);
        end else begin
            w_ang = POS_W'(w_ash);
        end
        if (r_reached3) begin
            w_lin = '0;
            w_ang = '0;
        end
    end

    logic                    r_ov;
    logic [SPD_W-1:0]        r_olin, r_slin;
    logic signed [POS_W-1:0] r_oang, r_sang;
    logic                    r_orch, r_srch;
    logic                    w_out_free;

    assign w_out_free = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (w_out_free) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= r_v3;
            end
        end else if (w_en && r_v3) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_sv) begin
                r_olin <= r_slin;
                r_oang <= r_sang;
                r_orch <= r_srch;
            end else begin
                r_olin <= w_lin;
                r_oang <= w_ang;
                r_orch <= r_reached3;
            end
        end else if (w_en) begin
            r_slin <= w_lin;
            r_sang <= w_ang;
            r_srch <= r_reached3;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_linear_speed  = r_olin;
    assign o_angular_speed = r_oang;
    assign o_goal_reached  = r_orch;

endmodule

// ----- tb/go_to_goal_p_controller_top_tb.sv -----
// ----------------------------------------------------------------------------
// go_to_goal_p_controller_top_tb
// self-checking bench for the go-to-goal proportional controller: poses are
// queued for a valid/ready driver, every input transfer is predicted by a
// bit-accurate cordic model of the block, and a monitor compares each output
// transfer with the oldest prediction while both sides idle and stall
// ----------------------------------------------------------------------------
module go_to_goal_p_controller_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import g2g_pkg::*;

    localparam int     STAGES          = 16;
    localparam int     ANG_SHR         = 39 - 12;
    localparam longint INV_GAIN        = 39797;
    localparam longint PI_SCALE        = 205887;
    localparam int     LATENCY         = STAGES + 6;
    localparam int     HOLD_CYCLES     = 300;
    localparam int     QUIET_LIMIT     = 4000;
    localparam int     ITEMS_PER_PHASE = 160;

    localparam logic [CFG_IDX_W-1:0]    CFG_UNUSED = 3'd7;
    localparam logic signed [POS_W-1:0] POS_MIN    = 20'sh80000;
    localparam logic signed [POS_W-1:0] POS_MAX    = 20'sh7FFFF;
    localparam logic signed [ANG_W-1:0] ANG_MIN    = 16'sh8000;
    localparam logic signed [ANG_W-1:0] ANG_MAX    = 16'sh7FFF;
    localparam logic [SPD_W-1:0]        SPD_MAX    = 19'h7FFFF;
    localparam logic [GAIN_W-1:0]       GAIN_MAX   = 12'hFFF;

    localparam logic [31:0] ATAN_LUT [STAGES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [ANG_W-1:0] hd;
    } t_pose;

    typedef struct packed {
        logic [SPD_W-1:0]        lin;
        logic signed [POS_W-1:0] ang;
        logic                    reached;
    } t_command;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]          i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic signed [POS_W-1:0]       i_pose_x = '0;
    logic signed [POS_W-1:0]       i_pose_y = '0;
    logic signed [ANG_W-1:0]       i_pose_heading = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [SPD_W-1:0]              o_linear_speed;
    logic signed [POS_W-1:0]       o_angular_speed;
    logic                          o_goal_reached;

    // controller settings as the block should hold them
    logic signed [POS_W-1:0] tgt_x = 20'sd45056;
    logic signed [POS_W-1:0] tgt_y = 20'sd45056;
    logic [SPD_W-1:0]        stop_dist = 19'd410;
    logic [GAIN_W-1:0]       lin_gain = 12'd384;
    logic [GAIN_W-1:0]       ang_gain = 12'd1536;
    logic [SPD_W-1:0]        lin_max = 19'd12288;
    logic [SPD_W-1:0]        ang_max = 19'd16384;

    t_pose    pending_poses[$];
    t_command expected_commands[$];
    int       sender_idle_pct = 0;
    int       receiver_stall_pct = 0;
    int       mismatches = 0;
    logic     hold_req = 1'b0;
    int       hold_left = 0;
    int       quiet_cycles = 0;

    go_to_goal_p_controller_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pose_x        (i_pose_x),
        .i_pose_y        (i_pose_y),
        .i_pose_heading  (i_pose_heading),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_linear_speed  (o_linear_speed),
        .o_angular_speed (o_angular_speed),
        .o_goal_reached  (o_goal_reached)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // distance and bearing of the vector to the target, cordic vectoring
    function automatic void polar_to_target(input longint dx, input longint dy,
                                            output longint distance,
                                            output logic [ANG_W-1:0] brg);
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        logic [31:0] z;
        logic [31:0] zr;
        x = dx * 256;
        y = dy * 256;
        z = '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_LUT[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_LUT[i];
            end
        end
        distance = (x * INV_GAIN + (64'sd1 <<< 23)) >>> 24;
        zr = z + 32'h0000_8000;
        brg = (dx == 0 && dy == 0) ? '0 : zr[31:16];
    endfunction

    function automatic logic [ANG_W-1:0] bearing_of(input t_pose p);
        longint           distance;
        logic [ANG_W-1:0] brg;
        polar_to_target(longint'(tgt_x) - longint'(p.x), longint'(tgt_y) - longint'(p.y),
                        distance, brg);
        return brg;
    endfunction

    function automatic t_command predict_command(input t_pose p);
        longint                  distance;
        longint                  lin;
        longint                  ang;
        logic [ANG_W-1:0]        brg;
        logic signed [ANG_W-1:0] err;
        t_command                c;
        c = '0;
        polar_to_target(longint'(tgt_x) - longint'(p.x), longint'(tgt_y) - longint'(p.y),
                        distance, brg);
        if (distance < longint'(stop_dist)) begin
            c.reached = 1'b1;
            return c;
        end
        err = brg - p.hd;
        lin = (distance * longint'(lin_gain) + 128) >>> 8;
        if (lin < 0) lin = 0;
        if (lin > longint'(lin_max)) lin = longint'(lin_max);
        ang = (longint'(err) * longint'(ang_gain) * PI_SCALE
               + (64'sd1 <<< (ANG_SHR - 1))) >>> ANG_SHR;
        if (ang > longint'(ang_max)) ang = longint'(ang_max);
        if (ang < -longint'(ang_max)) ang = -longint'(ang_max);
        c.lin = lin[SPD_W-1:0];
        c.ang = ang[POS_W-1:0];
        return c;
    endfunction

    function automatic logic signed [POS_W-1:0] edge_coord(input logic signed [POS_W-1:0] tgt);
        case ($urandom_range(4))
            0: return POS_MIN;
            1: return POS_MAX;
            2: return '0;
            3: return '1;
            default: return tgt;
        endcase
    endfunction

    function automatic t_pose random_pose();
        t_pose p;
        int    span;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            // around the target, straddling the stop distance
            span = (stop_dist > 19'd100000) ? 200000 : 2 * int'(stop_dist) + 16;
            p.x = POS_W'(int'(tgt_x) + int'($urandom_range(2 * span)) - span);
            p.y = POS_W'(int'(tgt_y) + int'($urandom_range(2 * span)) - span);
        end else if (pick < 42) begin
            p.x = edge_coord(tgt_x);
            p.y = edge_coord(tgt_y);
        end else begin
            p.x = POS_W'($urandom());
            p.y = POS_W'($urandom());
        end
        pick = $urandom_range(99);
        if (pick < 15) begin
            p.hd = bearing_of(p) + 16'h8000;
        end else if (pick < 25) begin
            p.hd = bearing_of(p);
        end else if (pick < 30) begin
            p.hd = $urandom_range(1) ? ANG_MAX : ANG_MIN;
        end else begin
            p.hd = ANG_W'($urandom());
        end
        return p;
    endfunction

    function automatic logic [CFG_DAT_W-1:0] random_limit();
        case ($urandom_range(3))
            0: return '0;
            1: return CFG_DAT_W'(SPD_MAX);
            2: return CFG_DAT_W'($urandom_range(65535));
            default: return CFG_DAT_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DAT_W-1:0] random_gain();
        case ($urandom_range(4))
            0: return '0;
            1: return CFG_DAT_W'(GAIN_MAX);
            default: return CFG_DAT_W'($urandom());
        endcase
    endfunction

    // called just after a rising edge; the block takes the write on the next one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_TARGET_X:      tgt_x = data;
            CFG_TARGET_Y:      tgt_y = data;
            CFG_STOP_DISTANCE: stop_dist = data[SPD_W-1:0];
            CFG_LINEAR_GAIN:   lin_gain = data[GAIN_W-1:0];
            CFG_ANGULAR_GAIN:  ang_gain = data[GAIN_W-1:0];
            CFG_MAX_LINEAR:    lin_max = data[SPD_W-1:0];
            CFG_MAX_ANGULAR:   ang_max = data[SPD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic randomise_config();
        write_reg(CFG_TARGET_X, $urandom_range(3) == 0 ? CFG_DAT_W'(edge_coord('0))
                                                       : CFG_DAT_W'($urandom()));
        write_reg(CFG_TARGET_Y, $urandom_range(3) == 0 ? CFG_DAT_W'(edge_coord('0))
                                                       : CFG_DAT_W'($urandom()));
        case ($urandom_range(4))
            0, 1: write_reg(CFG_STOP_DISTANCE, CFG_DAT_W'($urandom_range(4095)));
            2:    write_reg(CFG_STOP_DISTANCE, CFG_DAT_W'($urandom_range(200)));
            3:    write_reg(CFG_STOP_DISTANCE, CFG_DAT_W'($urandom()));
            default: write_reg(CFG_STOP_DISTANCE, random_limit());
        endcase
        write_reg(CFG_LINEAR_GAIN, random_gain());
        write_reg(CFG_ANGULAR_GAIN, random_gain());
        write_reg(CFG_MAX_LINEAR, random_limit());
        write_reg(CFG_MAX_ANGULAR, random_limit());
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_pose(input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
                            input logic signed [ANG_W-1:0] hd);
        t_pose p;
        p.x  = x;
        p.y  = y;
        p.hd = hd;
        pending_poses.push_back(p);
    endtask

    // heading placed at a fixed offset from the bearing to the target
    task automatic add_facing(input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
                              input logic [ANG_W-1:0] offset);
        t_pose p;
        p.x  = x;
        p.y  = y;
        p.hd = '0;
        p.hd = bearing_of(p) + offset;
        pending_poses.push_back(p);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_poses.size() != 0 || expected_commands.size() != 0 || i_in_valid);
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive_poses
        t_pose nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                nxt.x  = i_pose_x;
                nxt.y  = i_pose_y;
                nxt.hd = i_pose_heading;
                expected_commands.push_back(predict_command(nxt));
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_poses.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    nxt = pending_poses.pop_front();
                    i_in_valid     <= 1'b1;
                    i_pose_x       <= nxt.x;
                    i_pose_y       <= nxt.y;
                    i_pose_heading <= nxt.hd;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left   <= 0;
        end else if (hold_req) begin
            i_out_ready <= 1'b0;
            hold_left   <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_commands
        t_command want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_commands.size() == 0) begin
                $display("%0t: unexpected result transfer, linear %0d angular %0d reached %0b",
                         $time, o_linear_speed, o_angular_speed, o_goal_reached);
                mismatches++;
            end else begin
                want = expected_commands.pop_front();
                if (o_linear_speed !== want.lin) begin
                    $display("%0t: linear_speed expected %0d actual %0d",
                             $time, want.lin, o_linear_speed);
                    mismatches++;
                end
                if (o_angular_speed !== want.ang) begin
                    $display("%0t: angular_speed expected %0d actual %0d",
                             $time, want.ang, o_angular_speed);
                    mismatches++;
                end
                if (o_goal_reached !== want.reached) begin
                    $display("%0t: goal_reached expected %0b actual %0b",
                             $time, want.reached, o_goal_reached);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int mode;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: stop distance boundary, field extremes, wrap of the error
        @(negedge i_clk);
        add_pose(tgt_x, tgt_y, 16'sd0);
        add_pose(tgt_x - 20'sd300, tgt_y, 16'sd100);
        add_pose(tgt_x - 20'sd409, tgt_y, 16'sd0);
        add_pose(tgt_x - 20'sd411, tgt_y, 16'sd0);
        add_pose(tgt_x - 20'sd2000, tgt_y + 20'sd2000, -16'sd5000);
        add_pose(POS_MIN, POS_MIN, ANG_MIN);
        add_pose(POS_MAX, POS_MAX, ANG_MAX);
        add_pose(POS_MIN, POS_MAX, 16'sd0);
        add_pose(POS_MAX, POS_MIN, 16'sd1);
        add_pose(20'sd0, 20'sd0, 16'sd0);
        add_facing(20'sd0, tgt_y, 16'h8000);
        add_facing(20'sd0, 20'sd0, 16'h0000);
        add_facing(20'sd90000, tgt_y, 16'h8000);
        add_pose(20'sd100000, 20'sd12345, -16'sd20000);
        add_pose(tgt_x, POS_MIN, 16'sd0);
        add_pose(tgt_x, POS_MAX, 16'sd0);
        wait_drained();

        // target at the origin, no stop distance, gains and clamps at their top
        write_reg(CFG_TARGET_X, '0);
        write_reg(CFG_TARGET_Y, '0);
        write_reg(CFG_STOP_DISTANCE, '0);
        write_reg(CFG_LINEAR_GAIN, CFG_DAT_W'(GAIN_MAX));
        write_reg(CFG_ANGULAR_GAIN, CFG_DAT_W'(GAIN_MAX));
        write_reg(CFG_MAX_LINEAR, CFG_DAT_W'(SPD_MAX));
        write_reg(CFG_MAX_ANGULAR, CFG_DAT_W'(SPD_MAX));
        write_reg(CFG_UNUSED, '1);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        add_pose(20'sd0, 20'sd0, 16'sd12345);
        add_pose(-20'sd1, 20'sd0, 16'sd0);
        add_pose(20'sd0, -20'sd1, ANG_MIN);
        add_pose(POS_MIN, POS_MIN, 16'sd0);
        add_facing(POS_MAX, 20'sd0, 16'h8000);
        wait_drained();

        // target in a corner, largest stop distance, zero gains and clamps
        write_reg(CFG_TARGET_X, CFG_DAT_W'(POS_MIN));
        write_reg(CFG_TARGET_Y, CFG_DAT_W'(POS_MAX));
        write_reg(CFG_STOP_DISTANCE, CFG_DAT_W'(SPD_MAX));
        write_reg(CFG_LINEAR_GAIN, '0);
        write_reg(CFG_ANGULAR_GAIN, '0);
        write_reg(CFG_MAX_LINEAR, '0);
        write_reg(CFG_MAX_ANGULAR, '0);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        add_pose(POS_MAX, POS_MIN, 16'sd0);
        add_pose(POS_MIN, POS_MAX, 16'sd0);
        add_pose(POS_MAX, POS_MAX, ANG_MAX);
        wait_drained();

        // long receiver hold while the sender keeps offering
        randomise_config();
        @(negedge i_clk);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (ITEMS_PER_PHASE) pending_poses.push_back(random_pose());
        hold_req <= 1'b1;
        @(negedge i_clk);
        hold_req <= 1'b0;
        wait_drained();

        for (mode = 0; mode < 8; mode++) begin
            randomise_config();
            @(negedge i_clk);
            case (mode % 4)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 54;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 54;
                end
                default: begin
                    sender_idle_pct    = 14;
                    receiver_stall_pct = 14;
                end
            endcase
            repeat (ITEMS_PER_PHASE) pending_poses.push_back(random_pose());
            wait_drained();
        end

        repeat (2 * LATENCY) @(posedge i_clk);
        if (expected_commands.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_commands.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- go_to_goal_p_controller_top.f -----
design/g2g_pkg.sv
design/g2g_cordic.sv
design/go_to_goal_p_controller_top.sv
tb/go_to_goal_p_controller_top_tb.sv
